/* sv/ping_pong_capture_controller_assert.svh */
// Assertion helpers for the capture controller.
// Each check is compiled for simulation and drops out when SYNTHESIS is set.
`ifndef PING_PONG_CAPTURE_CONTROLLER_ASSERT_SVH
`define PING_PONG_CAPTURE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PPCC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PPCC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PPCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/ppcc_pkg.sv */
package ppcc_pkg;

   // event kinds
   localparam logic [2:0] ACT_CMD   = 3'd0;
   localparam logic [2:0] ACT_HALF  = 3'd1;
   localparam logic [2:0] ACT_FULL  = 3'd2;
   localparam logic [2:0] ACT_SEND  = 3'd3;
   localparam logic [2:0] ACT_ERROR = 3'd4;

   // host commands (top two bits of the request byte)
   localparam logic [1:0] CMD_STATUS = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_STOP   = 2'd2;
   localparam logic [1:0] CMD_RESET  = 2'd3;

   // status and error codes
   localparam logic [2:0] RC_OK      = 3'd0;
   localparam logic [2:0] RC_DMA     = 3'd1;
   localparam logic [2:0] RC_USB     = 3'd2;
   localparam logic [2:0] RC_BUSY    = 3'd3;
   localparam logic [2:0] RC_INVALID = 3'd4;
   localparam logic [2:0] RC_LINK    = 3'd6;
   localparam logic [2:0] RC_OVERRUN = 3'd7;

   // send results from the USB side
   localparam logic [1:0] SEND_OK   = 2'd0;
   localparam logic [1:0] SEND_BUSY = 2'd1;

   // buffer half selects
   localparam logic [1:0] HALF_NONE   = 2'd0;
   localparam logic [1:0] HALF_FIRST  = 2'd1;
   localparam logic [1:0] HALF_SECOND = 2'd2;

   // reply length a status command needs
   localparam logic [15:0] STATUS_REPLY_LEN = 16'd5;

   // request byte fields
   localparam int CMD_MSB = 7;
   localparam int CMD_LSB = 6;
   localparam int ARG_MSB = 5;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  request;
      logic [15:0] reply_length;
      logic        frame_error;
      logic        overrun;
      logic        dma_ok;
      logic [1:0]  usb_data_status;
      logic [1:0]  usb_zlp_status;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  state_code;
      logic [31:0] count_value;
      logic        channel_sel;
      logic [1:0]  send_half;
      logic [10:0] sample_count;
      logic        need_zlp;
      logic        start_capture;
      logic        stop_capture;
      logic        flush_usb;
      logic [2:0]  error_latched;
   } rsp_type;

endpackage

/* sv/ping_pong_capture_controller.sv */
// Channel   Direction  Handshake            Beat
// req_      in         req_valid/req_stall  one event or host command
// rsp_      out        rsp_valid/rsp_stall  one result per event
//
// Each beat is decoded against the current state in the cycle it is accepted; its
// result is on rsp_ next cycle unless held in skid; one per cycle if unstalled.
// A two-deep output stage (result register plus skid register) lets one more
// beat enter while a result is stalled; req_stall rises only when both are full.
// Reset (synchronous, active high) returns to idle, clears the error code,
// channel and sample counter, and empties the output stage.
`include "ping_pong_capture_controller_assert.svh"

module ping_pong_capture_controller
   import ppcc_pkg::*;
#(
   parameter int BUFFER_WORDS = 1024,
   parameter int PACKET_SIZE  = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // packet geometry: a quarter buffer of samples, three bytes each plus header
   localparam int          SAMPLES   = BUFFER_WORDS / 4;
   localparam int          PKT_BYTES = SAMPLES * 3 + 7;
   localparam logic        NEED_ZLP  = ((PKT_BYTES % PACKET_SIZE) == 0);
   localparam logic [10:0] SAMPLES_W = 11'(SAMPLES);
   localparam logic [31:0] SAMPLES_C = 32'(SAMPLES);

   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_ACQ10 = 3'd1,
      S_ACQ21 = 3'd2,
      S_ACQ31 = 3'd3,
      S_ACQ12 = 3'd4,
      S_ERROR = 3'd5
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic [2:0]     err_ff, err_in;
   logic           chan_ff, chan_in;
   logic [31:0]    count_ff, count_in;

   logic           out_valid_ff, skid_valid_ff;
   rsp_type        out_ff, skid_ff;
   rsp_type        result;

   logic           accept;
   logic           out_free;
   logic           acquiring;
   logic           fail_en;
   logic [2:0]     fail_code;
   logic [2:0]     status;
   ctrl_state_type hdr_state;
   logic [1:0]     cmd;
   logic [5:0]     arg;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign cmd       = req_data.request[CMD_MSB:CMD_LSB];
   assign arg       = req_data.request[ARG_MSB:0];
   assign acquiring = (state_ff == S_ACQ10) || (state_ff == S_ACQ21) ||
                      (state_ff == S_ACQ31) || (state_ff == S_ACQ12);

   // decode one beat against the current state
   always_comb begin
      state_in  = state_ff;
      err_in    = err_ff;
      chan_in   = chan_ff;
      count_in  = count_ff;
      fail_en   = 1'b0;
      fail_code = RC_OK;
      status    = RC_OK;
      hdr_state = S_IDLE;
      result    = '0;

      unique case (req_data.action)
         ACT_CMD: begin
            unique case (cmd)
               CMD_STATUS: begin
                  if (req_data.reply_length != STATUS_REPLY_LEN) begin
                     status = RC_INVALID;
                  end else begin
                     result.count_value = count_ff;
                  end
               end
               CMD_START: begin
                  if (state_ff != S_IDLE || arg > 6'd1) begin
                     status = RC_INVALID;
                  end else begin
                     chan_in              = arg[0];
                     state_in             = S_ACQ10;
                     result.start_capture = 1'b1;
                     if (!req_data.dma_ok) status = RC_DMA;
                  end
               end
               CMD_STOP: begin
                  if (!acquiring) begin
                     status = RC_INVALID;
                  end else begin
                     result.stop_capture = 1'b1;
                     result.flush_usb    = 1'b1;
                     state_in            = S_IDLE;
                     count_in            = '0;
                     if (!req_data.dma_ok) status = RC_DMA;
                  end
               end
               CMD_RESET: begin
                  if (state_ff != S_IDLE && state_ff != S_ERROR) begin
                     status = RC_INVALID;
                  end else begin
                     result.flush_usb = 1'b1;
                     state_in         = S_IDLE;
                     count_in         = '0;
                  end
               end
               default: ;
            endcase
         end
         ACT_HALF: begin
            if (state_ff == S_ACQ10) begin
               state_in = S_ACQ21;
            end else if (state_ff == S_ACQ12) begin
               fail_en   = 1'b1;
               fail_code = RC_OVERRUN;
            end
         end
         ACT_FULL: begin
            if (state_ff == S_ACQ31) begin
               state_in = S_ACQ12;
            end else if (state_ff == S_ACQ21) begin
               fail_en   = 1'b1;
               fail_code = RC_OVERRUN;
            end
         end
         ACT_SEND: begin
            if (req_data.frame_error) begin
               fail_en   = 1'b1;
               fail_code = RC_LINK;
            end else if (acquiring && req_data.overrun) begin
               fail_en   = 1'b1;
               fail_code = RC_OVERRUN;
            end else if (state_ff == S_ACQ21 || state_ff == S_ACQ12) begin
               // upload the filled half and advance on success
               hdr_state           = state_ff;
               result.send_half    = (state_ff == S_ACQ21) ? HALF_FIRST : HALF_SECOND;
               result.sample_count = SAMPLES_W;
               result.need_zlp     = NEED_ZLP;
               result.count_value  = count_ff;
               if (req_data.usb_data_status == SEND_BUSY) begin
                  status = RC_BUSY;
               end else if (req_data.usb_data_status != SEND_OK) begin
                  fail_en   = 1'b1;
                  fail_code = RC_USB;
                  status    = RC_USB;
               end else if (NEED_ZLP && req_data.usb_zlp_status == SEND_BUSY) begin
                  status = RC_BUSY;
               end else if (NEED_ZLP && req_data.usb_zlp_status != SEND_OK) begin
                  fail_en   = 1'b1;
                  fail_code = RC_USB;
                  status    = RC_USB;
               end else begin
                  count_in = count_ff + SAMPLES_C;
                  state_in = (state_ff == S_ACQ21) ? S_ACQ31 : S_ACQ10;
               end
            end
         end
         ACT_ERROR: begin
            if (req_data.frame_error) begin
               fail_en   = 1'b1;
               fail_code = RC_LINK;
            end else if (req_data.overrun) begin
               fail_en   = 1'b1;
               fail_code = RC_OVERRUN;
            end else if (acquiring) begin
               fail_en   = 1'b1;
               fail_code = RC_LINK;
            end
         end
         default: ;
      endcase

      // enter the error state: stop capture and flush the endpoint
      if (fail_en) begin
         state_in            = S_ERROR;
         err_in              = fail_code;
         result.stop_capture = 1'b1;
         result.flush_usb    = 1'b1;
      end

      result.status        = status;
      result.state_code    = (result.send_half != HALF_NONE) ? hdr_state : state_in;
      result.channel_sel   = chan_in;
      result.error_latched = err_in;
   end

   // hold state and the two-deep output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         err_ff        <= RC_OK;
         chan_ff       <= 1'b0;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
            err_ff   <= err_in;
            chan_ff  <= chan_in;
            count_ff <= count_in;
         end
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= accept;
            end else begin
               out_valid_ff <= accept;
            end
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // payload of the output stage
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff  <= skid_ff;
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   `PPCC_ASSERT_IMPL(a_skid_behind_out, clock, reset,
      skid_valid_ff, out_valid_ff, "skid full while output empty")
   `PPCC_ASSERT_NEXT(a_accept_gives_result, clock, reset,
      accept, out_valid_ff, "accepted beat left no result")
   `PPCC_ASSERT_IMPL(a_error_has_code, clock, reset,
      state_ff == S_ERROR, err_ff != RC_OK, "error state without error code")
   `PPCC_ASSERT_IMPL(a_idle_counter_clear, clock, reset,
      state_ff == S_IDLE, count_ff == 32'd0, "sample counter nonzero in idle")

endmodule
